// File: hw/rtl/pst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process scheduler tick: shared package
// Types, codes and helpers used by the scheduler cells and the top level.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int MAX_PROCS   = 32;
    localparam int MAX_ARRIVAL = 1000;
    localparam int SLOT_W      = $clog2(MAX_PROCS);
    localparam int CNT_W       = $clog2(MAX_PROCS + 1);
    localparam int DIV_STEPS   = 16;
    localparam int P1_STEPS    = (MAX_PROCS > DIV_STEPS) ? MAX_PROCS : DIV_STEPS;
    localparam int STEP_W      = $clog2(P1_STEPS);

    localparam logic [1:0] ALG_FCFS = 2'd0;
    localparam logic [1:0] ALG_SJF  = 2'd1;
    localparam logic [1:0] ALG_PRIO = 2'd2;
    localparam logic [1:0] ALG_RR   = 2'd3;

    localparam logic [2:0] CFG_ALGORITHM    = 3'd0;
    localparam logic [2:0] CFG_PREEMPTIVE   = 3'd1;
    localparam logic [2:0] CFG_TIME_QUANTUM = 3'd2;
    localparam logic [2:0] CFG_AGING_PERIOD = 3'd3;

    localparam logic [1:0] LST_ACCEPTED = 2'd0;
    localparam logic [1:0] LST_FULL     = 2'd1;
    localparam logic [1:0] LST_DUP      = 2'd2;
    localparam logic [1:0] LST_INVALID  = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [2:0] LOC_PENDING = 3'd0;
    localparam logic [2:0] LOC_READY   = 3'd1;
    localparam logic [2:0] LOC_WAITING = 3'd2;
    localparam logic [2:0] LOC_RUNNING = 3'd3;
    localparam logic [2:0] LOC_DONE    = 3'd4;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_P1_START = 4'd2;
    localparam logic [3:0] OP_P1_STEP  = 4'd3;
    localparam logic [3:0] OP_P1_APPLY = 4'd4;
    localparam logic [3:0] OP_P2_START = 4'd5;
    localparam logic [3:0] OP_P2_STEP  = 4'd6;
    localparam logic [3:0] OP_TAKE     = 4'd7;
    localparam logic [3:0] OP_UPDATE   = 4'd8;

    typedef struct packed {
        logic       command;
        logic [9:0] proc_id;
        logic [7:0] prio_value;
        logic [9:0] arrival_tick;
        logic [7:0] cpu_ticks;
        logic [7:0] io_ticks;
    } t_in;

    typedef struct packed {
        logic [1:0]  load_status;
        logic [15:0] tick_time;
        logic [9:0]  running_pid;
        logic        switched;
        logic [9:0]  done_pid;
        logic [15:0] done_waiting;
        logic [15:0] done_turnaround;
        logic [15:0] done_response;
        logic [5:0]  completed_count;
        logic [15:0] idle_ticks;
    } t_out;

    // Data that travels around the ring of cells, one hop per cycle.
    typedef struct packed {
        logic               arr;
        logic               fin;
        logic               rdy;
        logic [9:0]         pid;
        logic [SLOT_W-1:0]  slot;
        logic [SLOT_W-1:0]  wseq;
        logic [SLOT_W-1:0]  rseq;
        logic signed [15:0] key;
        logic [9:0]         arrival;
    } t_ring;

    typedef struct packed {
        logic [3:0]        op;
        logic [1:0]        alg;
        logic              ring_en;
        logic              div_en;
        logic [15:0]       time_now;
        logic [7:0]        per;
        logic [CNT_W-1:0]  loaded;
        logic [SLOT_W-1:0] wslot;
        t_in               rec;
        logic [SLOT_W-1:0] base_seq;
        logic [SLOT_W-1:0] wbase;
        logic [SLOT_W-1:0] take_slot;
        logic [SLOT_W-1:0] take_seq;
        logic              push;
        logic [SLOT_W-1:0] run_slot;
        logic              sw;
    } t_cell_ctl;

    typedef struct packed {
        logic              dup;
        logic              seq0;
        logic              best;
        logic              hit;
        logic [SLOT_W-1:0] rseq;
        logic [9:0]        pid;
        logic              done;
        logic              goes_wait;
        logic [15:0]       waiting;
        logic [15:0]       turn_new;
        logic [15:0]       resp_new;
        t_ring             ring;
    } t_cell_sts;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v != 16'hFFFF) ? v + 16'd1 : v;
    endfunction

endpackage

// File: hw/rtl/pst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process scheduler cell
// Holds one process slot, compares itself against the ring of its neighbors
// and ages its priority with a small serial divider.
// ----------------------------------------------------------------------------
module pst_cell (
    input  logic                      i_clk,
    input  logic [pst_pkg::SLOT_W-1:0] i_idx,
    input  pst_pkg::t_cell_ctl        i_ctl,
    input  pst_pkg::t_ring            i_ring,
    output pst_pkg::t_ring            o_ring,
    output pst_pkg::t_cell_sts        o_sts
);
    import pst_pkg::*;

    logic [2:0]         r_loc;
    logic [9:0]         r_pid;
    logic signed [15:0] r_prio;
    logic [9:0]         r_arr;
    logic [7:0]         r_cpu;
    logic [7:0]         r_io;
    logic [15:0]        r_wait;
    logic [15:0]        r_turn;
    logic [15:0]        r_resp;
    logic               r_resp_ok;
    logic [SLOT_W-1:0]  r_rseq;
    logic [SLOT_W-1:0]  r_wseq;
    logic [SLOT_W-1:0]  r_rank;
    logic               r_beaten;
    logic               r_hit;
    logic [7:0]         r_rem;
    logic [15:0]        r_dq;
    t_ring              r_ring;

    logic               used, is_rdy, is_run, is_wait, is_pend, arrive, fin;
    logic signed [15:0] key;
    t_ring              own;
    logic [8:0]         t9;
    logic               ge;
    logic [7:0]         rem_n;
    logic signed [17:0] v18;
    logic signed [15:0] aged;
    logic               arr_less, fin_less, beat, hitn;
    logic [7:0]         cpu_new;
    logic [15:0]        resp_new;

    always_comb begin
        used    = CNT_W'(i_idx) < i_ctl.loaded;
        is_rdy  = used && (r_loc == LOC_READY);
        is_run  = used && (r_loc == LOC_RUNNING);
        is_wait = used && (r_loc == LOC_WAITING);
        is_pend = used && (r_loc == LOC_PENDING);
        arrive  = is_pend && (i_ctl.time_now == 16'(r_arr));
        fin     = is_wait && (r_io <= 8'd1);
        key     = (i_ctl.alg == ALG_SJF) ? $signed({8'd0, r_cpu}) : r_prio;

        own.arr     = arrive;
        own.fin     = fin;
        own.rdy     = is_rdy;
        own.pid     = r_pid;
        own.slot    = i_idx;
        own.wseq    = r_wseq;
        own.rseq    = r_rseq;
        own.key     = key;
        own.arrival = r_arr;

        // One restoring division step per cycle while div_en is set: age / aging period.
        t9    = {r_rem, r_dq[15]};
        ge    = t9 >= {1'b0, i_ctl.per};
        rem_n = ge ? 8'(t9 - {1'b0, i_ctl.per}) : t9[7:0];
        v18   = 18'(r_prio) - $signed({2'b00, r_dq});
        aged  = (v18 < -18'sd32768) ? -16'sd32768 : v18[15:0];

        arr_less = r_ring.arr && ((r_ring.pid < r_pid) ||
                   ((r_ring.pid == r_pid) && (r_ring.slot < i_idx)));
        fin_less = r_ring.fin && (r_ring.wseq < r_wseq);
        hitn     = r_ring.rdy && ((r_ring.key < key) ||
                   ((r_ring.key == key) && (r_ring.arrival < r_arr)));
        beat     = r_ring.rdy && ((r_ring.key < key) || ((r_ring.key == key) &&
                   ((r_ring.arrival < r_arr) ||
                    ((r_ring.arrival == r_arr) && (r_ring.rseq < r_rseq)))));

        cpu_new  = (r_cpu != 8'd0) ? r_cpu - 8'd1 : r_cpu;
        resp_new = (i_ctl.sw && !r_resp_ok) ? i_ctl.time_now - 16'(r_arr) : r_resp;
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_LOAD: begin
                if (i_idx == i_ctl.wslot) begin
                    r_loc     <= LOC_PENDING;
                    r_pid     <= i_ctl.rec.proc_id;
                    r_prio    <= $signed({8'd0, i_ctl.rec.prio_value});
                    r_arr     <= i_ctl.rec.arrival_tick;
                    r_cpu     <= i_ctl.rec.cpu_ticks;
                    r_io      <= i_ctl.rec.io_ticks;
                    r_wait    <= '0;
                    r_turn    <= '0;
                    r_resp    <= '0;
                    r_resp_ok <= 1'b0;
                end
            end
            OP_P1_START: begin
                r_ring <= own;
                r_rank <= '0;
                r_dq   <= i_ctl.time_now - 16'(r_arr);
                r_rem  <= '0;
            end
            OP_P1_STEP: begin
                if (i_ctl.ring_en) begin
                    r_ring <= i_ring;
                    if ((arrive && arr_less) || (is_wait && fin_less)) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
                if (i_ctl.div_en) begin
                    r_rem <= rem_n;
                    r_dq  <= {r_dq[14:0], ge};
                end
            end
            OP_P1_APPLY: begin
                if (arrive) begin
                    r_loc  <= LOC_READY;
                    r_rseq <= i_ctl.base_seq + r_rank;
                end else if (is_rdy && (i_ctl.alg == ALG_PRIO) && (r_prio != 16'sd1)) begin
                    r_prio <= aged;
                end
            end
            OP_P2_START: begin
                r_ring   <= own;
                r_beaten <= 1'b0;
                r_hit    <= 1'b0;
            end
            OP_P2_STEP: begin
                r_ring <= i_ring;
                if (beat) begin
                    r_beaten <= 1'b1;
                end
                if (hitn) begin
                    r_hit <= 1'b1;
                end
            end
            OP_TAKE: begin
                if (used && (i_idx == i_ctl.take_slot)) begin
                    r_loc <= LOC_RUNNING;
                end else if (i_ctl.push && is_run && (i_idx == i_ctl.run_slot)) begin
                    r_loc  <= LOC_READY;
                    r_rseq <= i_ctl.base_seq;
                end else if (is_rdy && (r_rseq > i_ctl.take_seq)) begin
                    r_rseq <= r_rseq - 1'b1;
                end
            end
            OP_UPDATE: begin
                if (is_run) begin
                    r_resp <= resp_new;
                    if (i_ctl.sw) begin
                        r_resp_ok <= 1'b1;
                    end
                    r_cpu  <= cpu_new;
                    r_turn <= sat_inc16(r_turn);
                    if (cpu_new == 8'd0) begin
                        r_loc <= LOC_DONE;
                    end else if (r_io != 8'd0) begin
                        r_loc  <= LOC_WAITING;
                        r_wseq <= i_ctl.wbase;
                    end
                end else if (is_rdy) begin
                    r_wait <= sat_inc16(r_wait);
                    r_turn <= sat_inc16(r_turn);
                end else if (is_wait) begin
                    r_turn <= sat_inc16(r_turn);
                    if (r_io != 8'd0) begin
                        r_io <= r_io - 8'd1;
                    end
                    if (fin) begin
                        r_loc  <= LOC_READY;
                        r_rseq <= i_ctl.base_seq + r_rank;
                    end else begin
                        r_wseq <= r_wseq - r_rank;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_ring          = r_ring;
        o_sts.dup       = used && (r_pid == i_ctl.rec.proc_id);
        o_sts.seq0      = is_rdy && (r_rseq == '0);
        o_sts.best      = is_rdy && !r_beaten;
        o_sts.hit       = is_run && r_hit;
        o_sts.rseq      = r_rseq;
        o_sts.pid       = r_pid;
        o_sts.done      = cpu_new == 8'd0;
        o_sts.goes_wait = (cpu_new != 8'd0) && (r_io != 8'd0);
        o_sts.waiting   = r_wait;
        o_sts.turn_new  = sat_inc16(r_turn);
        o_sts.resp_new  = resp_new;
        o_sts.ring      = r_ring;
    end

endmodule

// File: hw/rtl/process_scheduler_tick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process scheduler tick
// Tick-driven CPU scheduler over a row of process cells joined in a ring.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A load item writes one
// process record unless it is invalid or the table is full; its result strobes
// on o_valid in the next cycle and busy never rises, so loads may follow each
// other in every cycle. A tick item holds busy high while the cells work: one
// pass around the ring ranks arrivals and finished IO (the per-cell age
// divider runs in the same pass), then the apply, select and update states
// follow. For shortest job and priority, with processes ready, a second ring
// pass and a pick state before the update find the best ready process. The
// result strobes on o_valid for one cycle as busy falls, and a new item may
// be started in that same cycle.
// Results cannot be held off; each is present for exactly one cycle.
// Configuration writes take effect at once and belong between items.
// Reset empties the table, clears the time and counters, restores default config.
// ----------------------------------------------------------------------------
module process_scheduler_tick (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pst_pkg::t_in  i_item,
    output logic          o_valid,
    output pst_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_data
);
    import pst_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_P1    = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_SEL   = 3'd3;
    localparam logic [2:0] S_P2    = 3'd4;
    localparam logic [2:0] S_PICK  = 3'd5;
    localparam logic [2:0] S_UPD   = 3'd6;

    logic [2:0]        r_state;
    logic [STEP_W-1:0] r_step;
    logic [1:0]        r_alg;
    logic              r_pre;
    logic [7:0]        r_quant;
    logic [7:0]        r_per;
    logic [CNT_W-1:0]  r_loaded, r_rcnt, r_wcnt, r_narr, r_nfin;
    logic              r_run_valid, r_prev_valid;
    logic [SLOT_W-1:0] r_run_slot, r_prev_slot;
    logic [7:0]        r_slice;
    logic [15:0]       r_time;
    logic [5:0]        r_done_total;
    logic [15:0]       r_idle;
    logic              r_valid;
    t_out              r_result;
    logic              n_valid;
    t_out              n_result;

    t_cell_ctl         ctl;
    t_ring             ring [MAX_PROCS];
    t_cell_sts         sts  [MAX_PROCS];

    logic              accept, invalid, full, dup_any, hit_any, best_any;
    logic [SLOT_W-1:0] seq0_slot, best_slot;
    logic [MAX_PROCS-1:0] best_vec;
    t_cell_sts         rs;
    logic              sw, keyed, take;

    genvar g;
    generate
        for (g = 0; g < MAX_PROCS; g++) begin : g_cell
            pst_cell u_cell (
                .i_clk  (i_clk),
                .i_idx  (SLOT_W'(g)),
                .i_ctl  (ctl),
                .i_ring (ring[(g + MAX_PROCS - 1) % MAX_PROCS]),
                .o_ring (ring[g]),
                .o_sts  (sts[g])
            );
        end
    endgenerate

    always_comb begin
        dup_any   = 1'b0;
        hit_any   = 1'b0;
        best_any  = 1'b0;
        seq0_slot = '0;
        best_slot = '0;
        for (int i = 0; i < MAX_PROCS; i++) begin
            dup_any     = dup_any | sts[i].dup;
            hit_any     = hit_any | sts[i].hit;
            best_any    = best_any | sts[i].best;
            best_vec[i] = sts[i].best;
            seq0_slot   = seq0_slot | (SLOT_W'(i) & {SLOT_W{sts[i].seq0}});
            best_slot   = best_slot | (SLOT_W'(i) & {SLOT_W{sts[i].best}});
        end
        rs = sts[r_run_slot];
    end

    always_comb begin
        busy    = r_state != S_IDLE;
        accept  = start && !busy;
        invalid = (i_item.proc_id == 10'd0) || (i_item.arrival_tick > 10'(MAX_ARRIVAL))
                  || (i_item.cpu_ticks == 8'd0);
        full    = r_loaded == CNT_W'(MAX_PROCS);
        keyed   = (r_alg == ALG_SJF) || (r_alg == ALG_PRIO);
        sw      = r_run_valid && (!r_prev_valid || (r_prev_slot != r_run_slot));
        take    = 1'b0;

        ctl           = '0;
        ctl.op        = OP_NONE;
        ctl.alg       = r_alg;
        ctl.time_now  = r_time;
        ctl.per       = (r_per == 8'd0) ? 8'd1 : r_per;
        ctl.loaded    = r_loaded;
        ctl.wslot     = SLOT_W'(r_loaded);
        ctl.rec       = i_item;
        ctl.run_slot  = r_run_slot;
        ctl.sw        = sw;
        ctl.ring_en   = r_step < STEP_W'(MAX_PROCS - 1) || r_step == STEP_W'(MAX_PROCS - 1);
        ctl.div_en    = r_step < STEP_W'(DIV_STEPS - 1) || r_step == STEP_W'(DIV_STEPS - 1);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.command == CMD_TICK) begin
                        ctl.op = OP_P1_START;
                    end else if (!invalid && !full) begin
                        ctl.op = OP_LOAD;
                    end
                end
            end
            S_P1: begin
                ctl.op = OP_P1_STEP;
            end
            S_APPLY: begin
                ctl.op       = OP_P1_APPLY;
                ctl.base_seq = SLOT_W'(r_rcnt);
            end
            S_SEL: begin
                if (r_rcnt != '0) begin
                    if (keyed) begin
                        ctl.op = OP_P2_START;
                    end else if (!r_run_valid) begin
                        take          = 1'b1;
                    end else if ((r_alg == ALG_RR) && (r_slice >= r_quant)) begin
                        take          = 1'b1;
                        ctl.push      = 1'b1;
                    end
                    ctl.take_slot = seq0_slot;
                    ctl.take_seq  = '0;
                end
            end
            S_P2: begin
                ctl.op      = OP_P2_STEP;
                ctl.ring_en = 1'b1;
            end
            S_PICK: begin
                ctl.take_slot = best_slot;
                ctl.take_seq  = sts[best_slot].rseq;
                if (!r_run_valid) begin
                    take = 1'b1;
                end else if (r_pre && hit_any) begin
                    take     = 1'b1;
                    ctl.push = 1'b1;
                end
            end
            S_UPD: begin
                ctl.op       = OP_UPDATE;
                ctl.base_seq = SLOT_W'(r_rcnt);
                ctl.wbase    = SLOT_W'(r_wcnt - r_nfin);
            end
            default: begin
            end
        endcase

        if (take) begin
            ctl.op       = OP_TAKE;
            ctl.base_seq = SLOT_W'(r_rcnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_alg        <= ALG_FCFS;
            r_pre        <= 1'b0;
            r_quant      <= 8'd4;
            r_per        <= 8'd20;
            r_loaded     <= '0;
            r_rcnt       <= '0;
            r_wcnt       <= '0;
            r_narr       <= '0;
            r_nfin       <= '0;
            r_run_valid  <= 1'b0;
            r_prev_valid <= 1'b0;
            r_run_slot   <= '0;
            r_prev_slot  <= '0;
            r_slice      <= '0;
            r_time       <= '0;
            r_done_total <= '0;
            r_idle       <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= n_valid;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ALGORITHM:    r_alg   <= i_cfg_data[1:0];
                    CFG_PREEMPTIVE:   r_pre   <= i_cfg_data[0];
                    CFG_TIME_QUANTUM: r_quant <= i_cfg_data;
                    CFG_AGING_PERIOD: r_per   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (ctl.op == OP_TAKE) begin
                r_run_slot  <= ctl.take_slot;
                r_run_valid <= 1'b1;
                r_rcnt      <= ctl.push ? r_rcnt : r_rcnt - 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_item.command == CMD_TICK) begin
                            r_state      <= S_P1;
                            r_step       <= '0;
                            r_narr       <= '0;
                            r_nfin       <= '0;
                            r_prev_valid <= r_run_valid;
                            r_prev_slot  <= r_run_slot;
                        end else begin
                            if (!invalid && !full) begin
                                r_loaded <= r_loaded + 1'b1;
                            end
                        end
                    end
                end
                S_P1: begin
                    if (ctl.ring_en) begin
                        r_narr <= r_narr + CNT_W'(sts[0].ring.arr);
                        r_nfin <= r_nfin + CNT_W'(sts[0].ring.fin);
                    end
                    if (r_step == STEP_W'(P1_STEPS - 1)) begin
                        r_state <= S_APPLY;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_APPLY: begin
                    r_rcnt  <= r_rcnt + r_narr;
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    r_step  <= '0;
                    r_state <= ((r_rcnt != '0) && keyed) ? S_P2 : S_UPD;
                end
                S_P2: begin
                    if (r_step == STEP_W'(MAX_PROCS - 1)) begin
                        r_state <= S_PICK;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_PICK: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_state <= S_IDLE;
                    r_time  <= r_time + 16'd1;
                    r_rcnt  <= r_rcnt + r_nfin;
                    if (r_run_valid) begin
                        r_slice <= sw ? 8'd1 : ((r_slice != 8'hFF) ? r_slice + 8'd1 : r_slice);
                        if (rs.done) begin
                            r_run_valid  <= 1'b0;
                            r_done_total <= r_done_total + 6'd1;
                            r_wcnt       <= r_wcnt - r_nfin;
                        end else if (rs.goes_wait) begin
                            r_run_valid <= 1'b0;
                            r_wcnt      <= r_wcnt - r_nfin + 1'b1;
                        end else begin
                            r_wcnt <= r_wcnt - r_nfin;
                        end
                    end else begin
                        r_idle <= sat_inc16(r_idle);
                        r_wcnt <= r_wcnt - r_nfin;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result register; loads report their status, ticks their schedule.
    always_comb begin
        n_valid  = 1'b0;
        n_result = r_result;
        if ((r_state == S_IDLE) && accept && (i_item.command == CMD_LOAD)) begin
            n_valid                  = 1'b1;
            n_result                 = '0;
            n_result.load_status     = invalid ? LST_INVALID :
                                       full    ? LST_FULL    :
                                       dup_any ? LST_DUP     : LST_ACCEPTED;
            n_result.completed_count = r_done_total;
            n_result.idle_ticks      = r_idle;
        end else if (r_state == S_UPD) begin
            n_valid              = 1'b1;
            n_result             = '0;
            n_result.load_status = LST_ACCEPTED;
            n_result.tick_time   = r_time;
            n_result.switched    = sw || !r_run_valid;
            if (r_run_valid) begin
                n_result.running_pid     = rs.pid;
                n_result.idle_ticks      = r_idle;
                if (rs.done) begin
                    n_result.done_pid        = rs.pid;
                    n_result.done_waiting    = rs.waiting;
                    n_result.done_turnaround = rs.turn_new;
                    n_result.done_response   = rs.resp_new;
                    n_result.completed_count = r_done_total + 6'd1;
                end else begin
                    n_result.completed_count = r_done_total;
                end
            end else begin
                n_result.idle_ticks      = sat_inc16(r_idle);
                n_result.completed_count = r_done_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Queues never hold more processes than the table.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_rcnt} + {1'b0, r_wcnt}) <= {1'b0, r_loaded})
        else $error("ready and waiting counts exceed loaded processes");

    // A load is answered in the very next cycle.
    a_load_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.command == CMD_LOAD)) |=> o_valid)
        else $error("load item without result");

    // The ring search leaves at most one best candidate, and one if any is ready.
    a_best_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |-> ($onehot0(best_vec) && (best_any || (r_rcnt == '0))))
        else $error("selection found several best processes");

endmodule
